// ----- sv/fpga_passive_serial_loader_core_defines.svh -----
// assertion macros for the passive serial loader
`ifndef FPGA_PASSIVE_SERIAL_LOADER_CORE_DEFINES_SVH
`define FPGA_PASSIVE_SERIAL_LOADER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication, checked while out of reset
`define FPL_ASSERT_IMP(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication, checked while out of reset
`define FPL_ASSERT_NXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define FPL_ASSERT_IMP(name, clk, rstn, ante, cons)
`define FPL_ASSERT_NXT(name, clk, rstn, ante, cons)
`endif

`endif

// ----- sv/fpl_pkg.sv -----
// types and codes shared by the passive serial loader modules
`default_nettype none
package fpl_pkg;

    localparam logic [1:0] MODE_START = 2'd0;
    localparam logic [1:0] MODE_TICK  = 2'd1;
    localparam logic [1:0] MODE_BYTE  = 2'd2;

    localparam logic [3:0] PH_IDLE        = 4'd0;
    localparam logic [3:0] PH_WAIT_LOW    = 4'd1;
    localparam logic [3:0] PH_SETTLE_LOW  = 4'd2;
    localparam logic [3:0] PH_SETTLE_HIGH = 4'd3;
    localparam logic [3:0] PH_WAIT_STATUS = 4'd4;
    localparam logic [3:0] PH_LOAD        = 4'd5;
    localparam logic [3:0] PH_FLUSH       = 4'd6;
    localparam logic [3:0] PH_OK          = 4'd7;
    localparam logic [3:0] PH_FAIL        = 4'd8;

    localparam logic       CFG_SETTLE_TICKS = 1'b0;
    localparam logic       CFG_FLUSH_CLOCKS = 1'b1;

    localparam logic [7:0]  SETTLE_RESET = 8'd1;
    localparam logic [15:0] FLUSH_RESET  = 16'd4000;
    localparam logic [2:0]  LAST_BEAT    = 3'd7;

    typedef struct packed {
        logic [1:0] mode;
        logic       status;
        logic       cdone;
        logic [7:0] data_byte;
        logic       last_byte;
    } item_t;

    typedef struct packed {
        logic [3:0]  phase;
        logic [7:0]  settle;
        logic [15:0] flush;
        logic        nconfig;
        logic        data;
    } core_state_t;

    // what the serializer needs to emit the results of one item
    typedef struct packed {
        logic       multi;
        logic       pulse;
        logic       ignored;
        logic       nconfig;
        logic       dlevel;
        logic [3:0] phase_old;
        logic [3:0] phase_new;
        logic [7:0] data_byte;
    } desc_t;

endpackage
`default_nettype wire

// ----- sv/fpl_step.sv -----
// next-state and result descriptor logic for one item
`default_nettype none
module fpl_step import fpl_pkg::*; (
    input  item_t       item,
    input  core_state_t st,
    input  logic [7:0]  settle_ticks,
    input  logic [15:0] flush_clocks,
    output core_state_t nxt,
    output desc_t       desc
);

    logic [7:0]  limit;
    logic [7:0]  cnt_inc;
    logic [15:0] flush_inc;

    assign limit     = (settle_ticks == 8'd0) ? 8'd1 : settle_ticks;
    assign cnt_inc   = (st.settle != 8'hFF) ? st.settle + 8'd1 : st.settle;
    assign flush_inc = st.flush + 16'd1;

    always_comb begin
        nxt            = st;
        desc.multi     = 1'b0;
        desc.pulse     = 1'b0;
        desc.ignored   = 1'b0;
        desc.phase_old = st.phase;
        desc.data_byte = item.data_byte;
        case (item.mode)
            MODE_START: begin
                nxt.nconfig = 1'b0;
                nxt.phase   = PH_WAIT_LOW;
                nxt.settle  = 8'd0;
                nxt.flush   = 16'd0;
            end
            MODE_TICK: begin
                case (st.phase)
                    PH_WAIT_LOW: begin
                        if (!item.status && !item.cdone) begin
                            nxt.phase  = PH_SETTLE_LOW;
                            nxt.settle = 8'd0;
                        end
                    end
                    PH_SETTLE_LOW: begin
                        if (cnt_inc >= limit) begin
                            nxt.nconfig = 1'b1;
                            nxt.phase   = PH_SETTLE_HIGH;
                            nxt.settle  = 8'd0;
                        end else begin
                            nxt.settle = cnt_inc;
                        end
                    end
                    PH_SETTLE_HIGH: begin
                        if (cnt_inc >= limit) begin
                            nxt.phase  = PH_WAIT_STATUS;
                            nxt.settle = 8'd0;
                        end else begin
                            nxt.settle = cnt_inc;
                        end
                    end
                    PH_WAIT_STATUS: begin
                        if (item.status) begin
                            nxt.phase = PH_LOAD;
                        end
                    end
                    PH_FLUSH: begin
                        if (st.flush >= flush_clocks) begin
                            nxt.phase = PH_OK;
                        end else begin
                            desc.pulse = 1'b1;
                            nxt.flush  = flush_inc;
                            if (flush_inc >= flush_clocks) begin
                                nxt.phase = PH_OK;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            MODE_BYTE: begin
                if (st.phase != PH_LOAD) begin
                    desc.ignored = 1'b1;
                end else begin
                    desc.multi = 1'b1;
                    desc.pulse = 1'b1;
                    nxt.data   = item.data_byte[0];
                    if (item.last_byte) begin
                        nxt.phase = PH_FAIL;
                    end else if (item.cdone) begin
                        nxt.flush = 16'd0;
                        nxt.phase = (flush_clocks != 16'd0) ? PH_FLUSH : PH_OK;
                    end
                end
            end
            default: ;
        endcase
        desc.nconfig   = nxt.nconfig;
        desc.dlevel    = nxt.data;
        desc.phase_new = nxt.phase;
    end

endmodule
`default_nettype wire

// ----- sv/fpl_ser.sv -----
// result register that emits one result, or eight serial bits of a byte
`default_nettype none
module fpl_ser import fpl_pkg::*; (
    input  wire        aclk,
    input  wire        aresetn,
    input  wire        load,
    input  desc_t      desc,
    output logic       free,
    output logic       m_tvalid,
    input  wire        m_tready,
    output logic [7:0] m_tdata,
    output logic       m_tlast
);

    logic       valid_reg, valid_next;
    logic [2:0] beat_reg, beat_next;
    desc_t      desc_reg, desc_next;
    logic       is_last;
    logic [3:0] phase_out;
    logic       level_out;

    assign is_last   = !desc_reg.multi || (beat_reg == LAST_BEAT);
    assign free      = !valid_reg || (m_tready && is_last);
    assign phase_out = is_last ? desc_reg.phase_new : desc_reg.phase_old;
    assign level_out = desc_reg.multi ? desc_reg.data_byte[7] : desc_reg.dlevel;

    always_comb begin
        valid_next = valid_reg;
        beat_next  = beat_reg;
        desc_next  = desc_reg;
        if (load) begin
            valid_next = 1'b1;
            beat_next  = 3'd0;
            desc_next  = desc;
        end else if (valid_reg && m_tready) begin
            if (is_last) begin
                valid_next = 1'b0;
            end else begin
                beat_next           = beat_reg + 3'd1;
                desc_next.data_byte = {desc_reg.data_byte[6:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            beat_reg  <= 3'd0;
        end else begin
            valid_reg <= valid_next;
            beat_reg  <= beat_next;
        end
        desc_reg <= desc_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tlast  = is_last;
    assign m_tdata  = {desc_reg.ignored, phase_out, desc_reg.pulse, level_out,
                       desc_reg.nconfig};

endmodule
`default_nettype wire

// ----- sv/fpga_passive_serial_loader_core.sv -----
// passive serial configuration master: top level
//
// usage
//   s_ channel: one transaction per command. tuser is the kind (start, tick,
//   data byte); tdata carries the sampled nSTATUS and CDONE levels and
//   the image byte; tlast marks the final byte of the image.
//   m_ channel: one transaction per result. a start, a tick, an ignored byte
//   or an unknown kind gives one result; a byte taken in the load phase gives
//   eight, MSB first, each carrying the DATA0 level and one DCLK pulse.
//   tlast marks the final result of a command.
//   cfg channel: settle ticks (index 0) and flush clocks (index 1), written
//   while no command is in flight; cfg_ready is always high.
// timing
//   a command is captured in the input register, then moves into the result
//   register, which drives m_tvalid, once that register is free.
//   single-result commands stream at one per cycle while m_tready is high;
//   a data byte holds the result register until all eight of its bits are
//   taken, which sets the byte rate.
// reset and stall
//   reset (aresetn low, synchronous) returns to idle with nCONFIG released
//   and both register defaults loaded. when m_tready is low the result
//   register holds, the input register fills and then s_tready drops.
`default_nettype none
`include "fpga_passive_serial_loader_core_defines.svh"
module fpga_passive_serial_loader_core import fpl_pkg::*; (
    input  wire         aclk,
    input  wire         aresetn,
    // command channel
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [15:0] s_tdata,   // status_pin, cdone_pin, data_byte[7:0], zero pad
    input  wire  [1:0]  s_tuser,   // mode
    input  wire         s_tlast,   // last_byte
    // result channel
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [7:0]  m_tdata,   // nconfig_level, data_level, clock_pulse, phase[3:0], ignored
    output logic        m_tlast,   // last result of the command
    // register write channel
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire         cfg_index,
    input  wire  [15:0] cfg_data
);

    // configuration registers
    logic [7:0]  settle_ticks_reg;
    logic [15:0] flush_clocks_reg;

    // input register
    logic        in_valid_reg, in_valid_next;
    item_t       item_reg, item_next;

    // sequencer state
    core_state_t state_reg, state_next;

    desc_t       desc;
    logic        ser_free;
    logic        step_fire;

    assign cfg_ready = 1'b1;

    // a command moves on once the result register can take its results
    assign step_fire = in_valid_reg && ser_free;
    assign s_tready  = !in_valid_reg || ser_free;

    always_comb begin
        in_valid_next = in_valid_reg;
        item_next     = item_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next       = 1'b1;
            item_next.mode      = s_tuser;
            item_next.status    = s_tdata[0];
            item_next.cdone     = s_tdata[1];
            item_next.data_byte = s_tdata[9:2];
            item_next.last_byte = s_tlast;
        end else if (step_fire) begin
            in_valid_next = 1'b0;
        end
    end

    fpl_step u_step (
        .item         (item_reg),
        .st           (state_reg),
        .settle_ticks (settle_ticks_reg),
        .flush_clocks (flush_clocks_reg),
        .nxt          (state_next),
        .desc         (desc)
    );

    fpl_ser u_ser (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (step_fire),
        .desc     (desc),
        .free     (ser_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            settle_ticks_reg  <= SETTLE_RESET;
            flush_clocks_reg  <= FLUSH_RESET;
            in_valid_reg      <= 1'b0;
            state_reg.phase   <= PH_IDLE;
            state_reg.settle  <= 8'd0;
            state_reg.flush   <= 16'd0;
            state_reg.nconfig <= 1'b1;
            state_reg.data    <= 1'b0;
        end else begin
            // register writes
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_SETTLE_TICKS) begin
                    settle_ticks_reg <= cfg_data[7:0];
                end else begin
                    flush_clocks_reg <= cfg_data;
                end
            end
            in_valid_reg <= in_valid_next;
            if (step_fire) begin
                state_reg <= state_next;
            end
        end
        item_reg <= item_next;
    end

    // nCONFIG is only held low while waiting for the device and settling low
    `FPL_ASSERT_IMP(a_nconfig_low_phase, aclk, aresetn, !state_reg.nconfig,
        (state_reg.phase == PH_WAIT_LOW) || (state_reg.phase == PH_SETTLE_LOW))
    // a pulsed result that is not the final one belongs to a byte in load
    `FPL_ASSERT_IMP(a_mid_byte_phase, aclk, aresetn,
        m_tvalid && !m_tlast, m_tdata[2] && (m_tdata[6:3] == PH_LOAD))
    // once a mid-byte bit is taken, the next bit follows at once
    `FPL_ASSERT_NXT(a_byte_continues, aclk, aresetn,
        m_tvalid && m_tready && !m_tlast, m_tvalid && m_tdata[2])
    // no command advances while the result register is still busy
    `FPL_ASSERT_IMP(a_step_needs_room, aclk, aresetn,
        m_tvalid && !m_tready, !step_fire)

endmodule
`default_nettype wire

// ----- dv/tb_top.sv -----
// self-checking testbench for the passive serial configuration master
module tb_top;
    import fpl_pkg::*;

    // the fourth command kind has no name in the package: it only reports the pins
    localparam logic [1:0] MODE_PEEK   = 2'd3;
    localparam int         CYCLE_LIMIT = 200000;

    // how a generated image ends
    localparam int END_FLUSH = 0;
    localparam int END_LAST  = 1;
    localparam int END_OPEN  = 2;

    typedef struct packed {
        logic       nconfig;
        logic       dlevel;
        logic       pulse;
        logic [3:0] phase;
        logic       ignored;
        logic       fin;
    } pin_result_t;

    typedef struct packed {
        logic        sel;
        logic [15:0] value;
    } reg_write_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic [15:0] s_tdata   = '0;
    logic [1:0]  s_tuser   = '0;
    logic        s_tlast   = 1'b0;
    logic        m_tready  = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_index = 1'b0;
    logic [15:0] cfg_data  = '0;
    wire         s_tready;
    wire         m_tvalid;
    wire  [7:0]  m_tdata;
    wire         m_tlast;
    wire         cfg_ready;

    fpga_passive_serial_loader_core u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    // loader state as the predictor sees it
    logic [7:0]  ld_settle_ticks = SETTLE_RESET;
    logic [15:0] ld_flush_clocks = FLUSH_RESET;
    logic [3:0]  ld_phase        = PH_IDLE;
    logic [7:0]  ld_settle_cnt   = '0;
    logic [15:0] ld_flush_cnt    = '0;
    logic        ld_nconfig      = 1'b1;
    logic        ld_dlevel       = 1'b0;

    item_t       cmd_q[$];
    pin_result_t pin_q[$];
    reg_write_t  reg_q[$];

    item_t       cur_cmd;
    pin_result_t want;
    reg_write_t  cur_reg;
    int          in_gap, out_stall;
    int          planned_cnt, taken_cnt, err_cnt, cycle_cnt;
    int          n_results, n_bytes, n_flush_pulses, n_ok, n_fail, n_reg_writes;
    logic        calm = 1'b0;
    logic [7:0]  plan_settle = SETTLE_RESET;
    logic [15:0] plan_flush  = FLUSH_RESET;

    function void post_result(logic pulse, logic ign, logic fin);
        pin_result_t r;
        r.nconfig = ld_nconfig;
        r.dlevel  = ld_dlevel;
        r.pulse   = pulse;
        r.phase   = ld_phase;
        r.ignored = ign;
        r.fin     = fin;
        pin_q.push_back(r);
    endfunction

    // zero settle ticks count as one; the counter saturates
    function automatic logic settle_elapsed();
        logic [7:0] lim;
        lim = (ld_settle_ticks != 8'd0) ? ld_settle_ticks : 8'd1;
        if (ld_settle_cnt < 8'd255)
            ld_settle_cnt++;
        return ld_settle_cnt >= lim;
    endfunction

    // advance the loader by one command and queue the pin results it causes
    function void loader_step(item_t it);
        logic pulse;
        int   i;
        pulse = 1'b0;
        case (it.mode)
            MODE_START: begin
                ld_nconfig    = 1'b0;
                ld_phase      = PH_WAIT_LOW;
                ld_settle_cnt = '0;
                ld_flush_cnt  = '0;
                post_result(1'b0, 1'b0, 1'b1);
            end
            MODE_TICK: begin
                case (ld_phase)
                    PH_WAIT_LOW: begin
                        if (!it.status && !it.cdone) begin
                            ld_phase      = PH_SETTLE_LOW;
                            ld_settle_cnt = '0;
                        end
                    end
                    PH_SETTLE_LOW: begin
                        if (settle_elapsed()) begin
                            ld_nconfig    = 1'b1;
                            ld_phase      = PH_SETTLE_HIGH;
                            ld_settle_cnt = '0;
                        end
                    end
                    PH_SETTLE_HIGH: begin
                        if (settle_elapsed()) begin
                            ld_phase      = PH_WAIT_STATUS;
                            ld_settle_cnt = '0;
                        end
                    end
                    PH_WAIT_STATUS: begin
                        if (it.status)
                            ld_phase = PH_LOAD;
                    end
                    PH_FLUSH: begin
                        if (ld_flush_cnt >= ld_flush_clocks) begin
                            // limit lowered below the pulses already given
                            ld_phase = PH_OK;
                        end else begin
                            pulse = 1'b1;
                            ld_flush_cnt++;
                            n_flush_pulses++;
                            if (ld_flush_cnt >= ld_flush_clocks)
                                ld_phase = PH_OK;
                        end
                        if (ld_phase == PH_OK)
                            n_ok++;
                    end
                    default: begin
                    end
                endcase
                post_result(pulse, 1'b0, 1'b1);
            end
            MODE_BYTE: begin
                if (ld_phase != PH_LOAD) begin
                    post_result(1'b0, 1'b1, 1'b1);
                end else begin
                    n_bytes++;
                    for (i = 0; i < 8; i++) begin
                        ld_dlevel = it.data_byte[7 - i];
                        if (i == 7) begin
                            if (it.last_byte) begin
                                ld_phase = PH_FAIL;
                                n_fail++;
                            end else if (it.cdone) begin
                                ld_flush_cnt = '0;
                                ld_phase = (ld_flush_clocks != 16'd0) ? PH_FLUSH : PH_OK;
                                if (ld_phase == PH_OK)
                                    n_ok++;
                            end
                        end
                        post_result(1'b1, 1'b0, i == 7);
                    end
                end
            end
            default: post_result(1'b0, 1'b0, 1'b1);
        endcase
    endfunction

    function void apply_reg(logic sel, logic [15:0] value);
        if (sel == CFG_SETTLE_TICKS)
            ld_settle_ticks = value[7:0];
        else
            ld_flush_clocks = value;
        n_reg_writes++;
    endfunction

    function void check_field(string name, int unsigned exp_v, int unsigned got_v);
        if (exp_v != got_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, got_v);
            err_cnt++;
        end
    endfunction

    // command driver: predicts on every accepted transaction
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                loader_step(cur_cmd);
                taken_cnt++;
            end
            if (!s_tvalid || s_tready) begin
                if (in_gap > 0) begin
                    in_gap--;
                    s_tvalid <= 1'b0;
                end else if (!calm && cmd_q.size() > 0 && $urandom_range(0, 6) == 0) begin
                    in_gap = $urandom_range(0, 2);
                    s_tvalid <= 1'b0;
                end else if (cmd_q.size() > 0) begin
                    cur_cmd = cmd_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= cur_cmd.mode;
                    s_tdata  <= {6'b0, cur_cmd.data_byte, cur_cmd.cdone, cur_cmd.status};
                    s_tlast  <= cur_cmd.last_byte;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // register write driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            cfg_valid <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready)
                apply_reg(cfg_index, cfg_data);
            if (!cfg_valid || cfg_ready) begin
                if (reg_q.size() > 0) begin
                    cur_reg = reg_q.pop_front();
                    cfg_valid <= 1'b1;
                    cfg_index <= cur_reg.sel;
                    cfg_data  <= cur_reg.value;
                end else begin
                    cfg_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor with random back-pressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                n_results++;
                if (pin_q.size() == 0) begin
                    $error("result transaction with nothing expected: tdata %h tlast %b",
                           m_tdata, m_tlast);
                    err_cnt++;
                end else begin
                    want = pin_q.pop_front();
                    check_field("nconfig_level", 32'(want.nconfig), 32'(m_tdata[0]));
                    check_field("data_level", 32'(want.dlevel), 32'(m_tdata[1]));
                    check_field("clock_pulse", 32'(want.pulse), 32'(m_tdata[2]));
                    check_field("phase", 32'(want.phase), 32'(m_tdata[6:3]));
                    check_field("ignored", 32'(want.ignored), 32'(m_tdata[7]));
                    check_field("last", 32'(want.fin), 32'(m_tlast));
                end
            end
            if (out_stall > 0) begin
                out_stall--;
                m_tready <= 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                out_stall = $urandom_range(0, 2);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("timeout with %0d results still expected", pin_q.size());
            $display("fpga_passive_serial_loader_core regression: fail");
            $finish;
        end
    end

    task automatic queue_item(logic [1:0] mode, logic status, logic cdone, logic [7:0] data,
                              logic lastb);
        item_t it;
        it.mode      = mode;
        it.status    = status;
        it.cdone     = cdone;
        it.data_byte = data;
        it.last_byte = lastb;
        cmd_q.push_back(it);
        planned_cnt++;
    endtask

    task automatic queue_tick(logic status, logic cdone);
        queue_item(MODE_TICK, status, cdone, 8'($urandom_range(0, 255)),
                   1'($urandom_range(0, 1)));
    endtask

    // any kind, any pins: restarts, stray bytes and ticks break the sequence
    task automatic maybe_noise(logic noisy);
        if (noisy && $urandom_range(0, 9) == 0)
            queue_item(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                       1'($urandom_range(0, 1)));
    endtask

    task automatic bring_up(int settle, logic noisy);
        logic [1:0] pins;
        int         lim;
        lim = (settle == 0) ? 1 : settle;
        queue_item(MODE_START, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                   8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        // the target still holds one of its pins high
        repeat ($urandom_range(0, 2)) begin
            pins = 2'($urandom_range(1, 3));
            queue_tick(pins[0], pins[1]);
        end
        maybe_noise(noisy);
        queue_tick(1'b0, 1'b0);
        repeat (2 * lim)
            queue_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        maybe_noise(noisy);
        repeat ($urandom_range(0, 2))
            queue_tick(1'b0, 1'($urandom_range(0, 1)));
        queue_tick(1'b1, 1'($urandom_range(0, 1)));
    endtask

    task automatic load_image(int nbytes, int ending, logic noisy);
        repeat (nbytes) begin
            queue_item(MODE_BYTE, 1'($urandom_range(0, 1)), 1'b0,
                       8'($urandom_range(0, 255)), 1'b0);
            maybe_noise(noisy);
            if ($urandom_range(0, 7) == 0)
                queue_item($urandom_range(0, 1) ? MODE_TICK : MODE_PEEK,
                           1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                           8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end
        if (ending == END_FLUSH)
            queue_item(MODE_BYTE, 1'($urandom_range(0, 1)), 1'b1,
                       8'($urandom_range(0, 255)), 1'b0);
        else if (ending == END_LAST)
            queue_item(MODE_BYTE, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                       8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic run_session(logic noisy);
        int ending;
        ending = $urandom_range(0, 3);
        if (ending == 3)
            ending = END_FLUSH;
        bring_up(int'(plan_settle), noisy);
        load_image($urandom_range(1, 6), ending, noisy);
        if (ending == END_FLUSH)
            repeat (int'(plan_flush) + $urandom_range(0, 2))
                queue_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        queue_item(MODE_PEEK, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                   8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    endtask

    // wait until every command is taken and every result seen, then let the pipe empty
    task automatic wait_idle();
        while (!(taken_cnt == planned_cnt && pin_q.size() == 0))
            @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic set_regs(logic [7:0] settle, logic [15:0] flush);
        reg_write_t w;
        w.sel   = CFG_SETTLE_TICKS;
        w.value = {8'($urandom_range(0, 255)), settle};
        reg_q.push_back(w);
        w.sel   = CFG_FLUSH_CLOCKS;
        w.value = flush;
        reg_q.push_back(w);
        while (reg_q.size() > 0 || cfg_valid)
            @(negedge aclk);
        plan_settle = settle;
        plan_flush  = flush;
    endtask

    initial begin
        int goal;
        int ph;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed bring-up and load with reset register values
        queue_item(MODE_PEEK, 1'b1, 1'b1, 8'hFF, 1'b1);
        queue_tick(1'b0, 1'b0);
        queue_item(MODE_BYTE, 1'b1, 1'b1, 8'hFF, 1'b1);
        queue_item(MODE_START, 1'b0, 1'b0, 8'h00, 1'b0);
        queue_tick(1'b1, 1'b0);
        queue_tick(1'b0, 1'b1);
        queue_tick(1'b0, 1'b0);
        queue_tick(1'b1, 1'b1);
        queue_tick(1'b1, 1'b1);
        queue_tick(1'b0, 1'b0);
        queue_tick(1'b1, 1'b0);
        queue_tick(1'b0, 1'b0);
        queue_item(MODE_PEEK, 1'b0, 1'b0, 8'h00, 1'b0);
        queue_item(MODE_BYTE, 1'b0, 1'b0, 8'h00, 1'b0);
        queue_item(MODE_BYTE, 1'b1, 1'b0, 8'hFF, 1'b0);
        queue_item(MODE_BYTE, 1'b0, 1'b1, 8'hA5, 1'b0);
        repeat (3) queue_tick(1'b0, 1'b1);
        wait_idle();
        // flush limit lowered below the pulses already given
        set_regs(8'd1, 16'd2);
        queue_tick(1'b0, 1'b1);
        queue_tick(1'b1, 1'b1);
        queue_item(MODE_BYTE, 1'b0, 1'b0, 8'h3C, 1'b0);
        queue_item(MODE_START, 1'b1, 1'b1, 8'hFF, 1'b1);
        wait_idle();

        // zero settle and zero flush: straight to ok, then a last byte with CDONE high
        set_regs(8'd0, 16'd0);
        bring_up(0, 1'b0);
        load_image(2, END_FLUSH, 1'b0);
        bring_up(0, 1'b0);
        load_image(1, END_OPEN, 1'b0);
        queue_item(MODE_BYTE, 1'b0, 1'b1, 8'h81, 1'b1);
        wait_idle();

        // largest settle value: the saturating counter has to reach its top
        set_regs(8'd255, 16'hFFFF);
        queue_item(MODE_START, 1'b0, 1'b0, 8'h00, 1'b0);
        queue_tick(1'b0, 1'b0);
        repeat (255)
            queue_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        wait_idle();
        // short settle for the rest of the bring-up, then the largest flush limit
        set_regs(8'd1, 16'hFFFF);
        queue_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        queue_tick(1'b1, 1'($urandom_range(0, 1)));
        load_image(2, END_FLUSH, 1'b0);
        repeat (4) queue_tick(1'b0, 1'b1);
        wait_idle();

        // random sessions under random small settings; the last phase runs without random gaps or back-pressure
        for (ph = 0; ph < 4; ph++) begin
            set_regs(($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom_range(1, 6)),
                     16'($urandom_range(0, 12)));
            if (ph == 3)
                calm = 1'b1;
            goal = planned_cnt + 10;
            while (planned_cnt < goal)
                run_session(1'b1);
            wait_idle();
        end

        repeat (10) @(negedge aclk);
        $display("%0d commands, %0d result transactions, %0d register writes",
                 taken_cnt, n_results, n_reg_writes);
        $display("%0d bytes shifted, %0d flush pulses, %0d loads ok, %0d loads failed",
                 n_bytes, n_flush_pulses, n_ok, n_fail);
        if (err_cnt == 0)
            $display("fpga_passive_serial_loader_core regression: pass");
        else
            $display("fpga_passive_serial_loader_core regression: fail");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/fpl_pkg.sv
sv/fpl_step.sv
sv/fpl_ser.sv
sv/fpga_passive_serial_loader_core.sv
dv/tb_top.sv
